// ===== sv/tile_map_store_and_lookup_top_macros.svh =====
// Assertion macros shared by the tile map RTL.
`ifndef TILE_MAP_STORE_AND_LOOKUP_TOP_MACROS_SVH
`define TILE_MAP_STORE_AND_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TMSL_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("tmsl assertion failed");
`define TMSL_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("tmsl assertion failed");
`else
`define TMSL_ASSERT_IMP(lbl, a, c)
`define TMSL_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/tmsl_pkg.sv =====
package tmsl_pkg;

	localparam int MAP_DEPTH  = 4096;
	localparam int ADDR_W     = $clog2(MAP_DEPTH);
	localparam int IDX_W      = 19;
	localparam int DIVD_W     = IDX_W;
	localparam int DIVS_W     = 11;
	localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

	typedef enum logic [2:0] {
		OP_RD_RAW  = 3'd0,
		OP_RD_UNP  = 3'd1,
		OP_WR_RAW  = 3'd2,
		OP_WR_FLAG = 3'd3,
		OP_DRAW    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_MAP_WIDTH  = 3'd0,
		REG_MAP_HEIGHT = 3'd1,
		REG_ATLAS_COLS = 3'd2,
		REG_TILE_W     = 3'd3,
		REG_TILE_H     = 3'd4,
		REG_PADDING    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== sv/tmsl_div.sv =====
`include "tile_map_store_and_lookup_top_macros.svh"

module tmsl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tmsl_pkg::DIVD_W-1:0]   dividend,
	input  logic [tmsl_pkg::DIVS_W-1:0]   divisor,
	output logic [tmsl_pkg::DIVD_W-1:0]   quotient,
	output logic [tmsl_pkg::DIVS_W-1:0]   remainder,
	output tmsl_pkg::div_sts_t            sts
);
	import tmsl_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    div_q;
	logic [DIVS_W:0]      shift;
	logic [DIVS_W+1:0]    trial;

	assign shift = {rem_q, quo_q[DIVD_W-1]};
	assign trial = {1'b0, shift} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIVS_W+1]) begin
				rem_q <= trial[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shift[DIVS_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

	`TMSL_ASSERT_IMP(a_start_when_idle, start, !busy_q)
	`TMSL_ASSERT_NXT(a_done_ends_busy, done_q, !busy_q && !done_q)
	`TMSL_ASSERT_IMP(a_rem_below_div, done_q, rem_q < div_q)

endmodule

// ===== sv/tile_map_store_and_lookup_top.sv =====
// Tile map store with lookup. A store of 4096 32-bit tile words is addressed by
// cell_x + cell_y*map_width and bounds-checked against map_width*map_height and
// the store depth. After reset a clearing pass zeroes the store; no input
// transfer is taken during it, register writes are. One item is worked at a
// time. A full draw cell uses the 19-step restoring divider that splits the
// tile index into atlas column and row; all operations share one multiplier
// that forms one product per cycle. s_tuser carries the opcode. Results wait
// in an output register, so the next item is taken while a result is still
// unclaimed.
`include "tile_map_store_and_lookup_top_macros.svh"

module tile_map_store_and_lookup_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_x[13:0], cell_y[27:14], write_word[59:28], set_mirror[60],
	// set_flip[61], set_rotate[62], zero[63]
	input  logic [63:0]  s_tdata,
	// opcode[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// raw_word[31:0], tile_index[50:32], is_mirrored[51], is_flipped[52],
	// is_rotated[53], in_range[54], draw_skip[55], texel_x[74:56],
	// texel_y[93:75], centre_x[115:94], centre_y[137:116], zero[143:138]
	output logic [143:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tmsl_pkg::*;

	localparam int POS_W  = 28;
	localparam int PROD_W = 34;
	localparam int CEN_W  = 22;
	localparam logic signed [PROD_W-1:0] CEN_MAX = PROD_W'((2 ** (CEN_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] CEN_MIN = -PROD_W'(2 ** (CEN_W - 1));

	typedef enum logic [14:0] {
		S_CLR  = 15'h0001,
		S_IDLE = 15'h0002,
		S_POS  = 15'h0004,
		S_LIM  = 15'h0008,
		S_CHK  = 15'h0010,
		S_MEM  = 15'h0020,
		S_WORD = 15'h0040,
		S_CX   = 15'h0080,
		S_CY   = 15'h0100,
		S_DST  = 15'h0200,
		S_DIV  = 15'h0400,
		S_TX   = 15'h0800,
		S_TY   = 15'h1000,
		S_TFIN = 15'h2000,
		S_OUT  = 15'h4000
	} state_t;

	state_t state_q;

	logic [12:0] mw_q;
	logic [12:0] mh_q;
	logic [10:0] cols_q;
	logic [8:0]  tw_q;
	logic [8:0]  th_q;
	logic [3:0]  pad_q;

	logic [ADDR_W-1:0] clr_q;
	logic              mv_q;

	op_t                      op_q;
	logic signed [13:0]       x_q;
	logic signed [13:0]       y_q;
	logic [31:0]              wval_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [POS_W-1:0]  pos_q;
	logic                     ok_q;
	logic [31:0]              rd_q;
	logic [31:0]              word_q;
	logic signed [CEN_W-1:0]  cx_q;
	logic signed [CEN_W-1:0]  cy_q;
	logic [IDX_W-1:0]         tx_q;
	logic [IDX_W-1:0]         ty_q;
	logic                     skip_q;
	logic [143:0]             out_q;

	logic [31:0] mem_q [MAP_DEPTH];

	logic                     s_acc;
	logic                     cfg_wr;
	logic                     out_load;
	logic                     is_wr;
	logic                     dst_skip;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_addr;
	logic [31:0]              mem_wd;
	logic signed [19:0]       mul_a;
	logic signed [13:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [9:0]               step_x;
	logic [9:0]               step_y;
	logic [DIVS_W-1:0]        div_cols;
	logic                     div_start;
	logic [DIVD_W-1:0]        div_quo;
	logic [DIVS_W-1:0]        div_rem;
	div_sts_t                 div_sts;
	logic [31:0]              s_wval;

	function automatic logic signed [CEN_W-1:0] sat_cen(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		r = v;
		if (v > CEN_MAX)
			r = CEN_MAX;
		if (v < CEN_MIN)
			r = CEN_MIN;
		return r[CEN_W-1:0];
	endfunction

	assign pready   = 1'b1;
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == S_OUT) && (!mv_q || m_tready);
	assign is_wr    = (op_q == OP_WR_RAW) || (op_q == OP_WR_FLAG);
	assign dst_skip = !ok_q || (word_q[IDX_W-1:0] == '0);
	assign div_cols = (cols_q == '0) ? DIVS_W'(1) : cols_q;
	assign div_start = (state_q == S_DST) && !dst_skip;
	assign step_x   = {1'b0, tw_q} + {5'b0, pad_q, 1'b0};
	assign step_y   = {1'b0, th_q} + {5'b0, pad_q, 1'b0};
	assign s_wval   = (op_t'(s_tuser) == OP_WR_FLAG) ?
	                  (s_tdata[59:28] | {1'b0, s_tdata[62:60], 28'b0}) : s_tdata[59:28];

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_MAP_WIDTH:  prdata = {19'b0, mw_q};
			REG_MAP_HEIGHT: prdata = {19'b0, mh_q};
			REG_ATLAS_COLS: prdata = {21'b0, cols_q};
			REG_TILE_W:     prdata = {23'b0, tw_q};
			REG_TILE_H:     prdata = {23'b0, th_q};
			REG_PADDING:    prdata = {28'b0, pad_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_POS: begin
				mul_a = 20'(y_q);
				mul_b = {1'b0, mw_q};
			end
			S_LIM: begin
				mul_a = {7'b0, mh_q};
				mul_b = {1'b0, mw_q};
			end
			S_CX: begin
				mul_a = 20'(x_q);
				mul_b = {5'b0, tw_q};
			end
			S_CY: begin
				mul_a = 20'(y_q);
				mul_b = {5'b0, th_q};
			end
			S_TX: begin
				mul_a = {9'b0, div_rem};
				mul_b = {4'b0, step_x};
			end
			S_TY: begin
				mul_a = {1'b0, div_quo};
				mul_b = {4'b0, step_y};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign mem_we   = (state_q == S_CLR) || ((state_q == S_MEM) && is_wr && ok_q);
	assign mem_addr = (state_q == S_CLR) ? clr_q : pos_q[ADDR_W-1:0];
	assign mem_wd   = (state_q == S_CLR) ? 32'b0 : wval_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_addr] <= mem_wd;
		rd_q <= mem_q[mem_addr];
	end

	tmsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (word_q[IDX_W-1:0]),
		.divisor   (div_cols),
		.quotient  (div_quo),
		.remainder (div_rem),
		.sts       (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			mv_q    <= 1'b0;
			mw_q    <= 13'd64;
			mh_q    <= 13'd64;
			cols_q  <= 11'd16;
			tw_q    <= 9'd16;
			th_q    <= 9'd16;
			pad_q   <= 4'd0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_MAP_WIDTH:  mw_q   <= pwdata[12:0];
					REG_MAP_HEIGHT: mh_q   <= pwdata[12:0];
					REG_ATLAS_COLS: cols_q <= pwdata[10:0];
					REG_TILE_W:     tw_q   <= pwdata[8:0];
					REG_TILE_H:     th_q   <= pwdata[8:0];
					REG_PADDING:    pad_q  <= pwdata[3:0];
					default: ;
				endcase
			end

			if (out_load)
				mv_q <= 1'b1;
			else if (m_tready)
				mv_q <= 1'b0;

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MAP_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_acc && (s_tuser inside {OP_RD_RAW, OP_RD_UNP, OP_WR_RAW,
					                              OP_WR_FLAG, OP_DRAW}))
						state_q <= S_POS;
				end
				S_POS:  state_q <= S_LIM;
				S_LIM:  state_q <= S_CHK;
				S_CHK:  state_q <= S_MEM;
				S_MEM:  state_q <= is_wr ? S_IDLE : S_WORD;
				S_WORD: state_q <= (op_q == OP_DRAW) ? S_CX : S_OUT;
				S_CX:   state_q <= S_CY;
				S_CY:   state_q <= S_DST;
				S_DST:  state_q <= dst_skip ? S_OUT : S_DIV;
				S_DIV: begin
					if (div_sts.done)
						state_q <= S_TX;
				end
				S_TX:   state_q <= S_TY;
				S_TY:   state_q <= S_TFIN;
				S_TFIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q   <= op_t'(s_tuser);
			x_q    <= s_tdata[13:0];
			y_q    <= s_tdata[27:14];
			wval_q <= s_wval;
		end

		case (state_q)
			S_POS, S_LIM, S_CX, S_CY, S_TX, S_TY: prod_q <= mul_p;
			default: ;
		endcase

		case (state_q)
			S_LIM: pos_q <= POS_W'(x_q) + $signed(prod_q[POS_W-1:0]);
			S_CHK: ok_q <= (pos_q >= 0) && (pos_q < $signed(prod_q[POS_W-1:0])) &&
			               (pos_q < $signed(POS_W'(MAP_DEPTH)));
			S_WORD: begin
				word_q <= ok_q ? rd_q : 32'b0;
				if (op_q != OP_DRAW) begin
					cx_q   <= '0;
					cy_q   <= '0;
					tx_q   <= '0;
					ty_q   <= '0;
					skip_q <= 1'b0;
				end
			end
			S_CY: cx_q <= sat_cen(prod_q + $signed(PROD_W'(tw_q[8:1])));
			S_DST: begin
				cy_q   <= sat_cen(prod_q + $signed(PROD_W'(th_q[8:1])));
				skip_q <= dst_skip;
				if (dst_skip) begin
					tx_q <= '0;
					ty_q <= '0;
				end
			end
			S_TY:   tx_q <= IDX_W'(pad_q) + prod_q[IDX_W-1:0];
			S_TFIN: ty_q <= IDX_W'(pad_q) + prod_q[IDX_W-1:0];
			default: ;
		endcase

		if (out_load)
			out_q <= {6'b0, cy_q, cx_q, ty_q, tx_q, skip_q, ok_q,
			          word_q[30], word_q[29], word_q[28], word_q[IDX_W-1:0], word_q};
	end

	`TMSL_ASSERT_IMP(a_clr_no_result, state_q == S_CLR, !m_tvalid && !s_tready)
	`TMSL_ASSERT_IMP(a_store_write_ok, mem_we && state_q != S_CLR, ok_q && is_wr)
	`TMSL_ASSERT_IMP(a_div_done_waits, div_sts.done, state_q == S_DIV)
	`TMSL_ASSERT_NXT(a_load_gives_valid, out_load, m_tvalid && state_q == S_IDLE)

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmsl_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int IDLE_PCT = 12;
	localparam int MIRROR_BIT = 28;
	localparam int FLIP_BIT = 29;
	localparam int ROTATE_BIT = 30;
	localparam logic [2:0] OP_SPARE_LO = 3'(OP_DRAW + 1);
	localparam logic [2:0] OP_SPARE_HI = '1;

	// cell_x, cell_y, write_word, set_mirror, set_flip, set_rotate from the low bit up
	typedef struct packed {
		logic        fill;
		logic        rot;
		logic        flp;
		logic        mir;
		logic [31:0] word;
		logic [13:0] cy;
		logic [13:0] cx;
	} cell_req_t;

	// raw_word, tile_index, flags, in_range, draw_skip, texels, centres from the low bit up
	typedef struct packed {
		logic [5:0]         fill;
		logic signed [21:0] centre_y;
		logic signed [21:0] centre_x;
		logic [18:0]        texel_y;
		logic [18:0]        texel_x;
		logic               draw_skip;
		logic               in_range;
		logic               is_rotated;
		logic               is_flipped;
		logic               is_mirrored;
		logic [18:0]        tile_index;
		logic [31:0]        raw_word;
	} cell_res_t;

	typedef struct {
		logic [2:0]  op;
		int          x;
		int          y;
		logic [31:0] word;
		logic [2:0]  flags;
		bit          pinned;
		bit          e_inr;
		bit          e_skip;
		int          e_cx;
		int          e_cy;
	} script_row_t;

	typedef struct {
		int w;
		int h;
		int cols;
		int tw;
		int th;
		int pad;
	} map_shape_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	logic [31:0] tile_words [MAP_DEPTH];
	logic [12:0] grid_w = 13'd64;
	logic [12:0] grid_h = 13'd64;
	logic [10:0] sheet_cols = 11'd16;
	logic [8:0]  tw_px = 9'd16;
	logic [8:0]  th_px = 9'd16;
	logic [3:0]  gutter = 4'd0;

	cell_res_t expected_cells [$];
	int        mismatches = 0;
	int        cells_seen = 0;
	int        quiet_cycles = 0;
	bit        steady = 1'b0;

	tile_map_store_and_lookup_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		foreach (tile_words[i])
			tile_words[i] = '0;
	end

	function automatic logic [21:0] pixel_centre(input longint c, input logic [8:0] size);
		longint v;
		v = c * longint'(size) + longint'(size / 2);
		if (v > 2097151)
			v = 2097151;
		if (v < -2097152)
			v = -2097152;
		return 22'(v);
	endfunction

	function automatic bit lookup_cell(input logic [2:0] op, input cell_req_t r,
		output cell_res_t e);
		longint      x, y, p, lim, idx, n;
		logic [31:0] w;
		bit          ok;
		x = longint'($signed(r.cx));
		y = longint'($signed(r.cy));
		p = x + y * longint'(grid_w);
		lim = longint'(grid_w) * longint'(grid_h);
		ok = p >= 0 && p < lim && p < MAP_DEPTH;
		e = '0;
		if (op == OP_WR_RAW || op == OP_WR_FLAG) begin
			w = r.word;
			if (op == OP_WR_FLAG) begin
				w[MIRROR_BIT] = w[MIRROR_BIT] | r.mir;
				w[FLIP_BIT] = w[FLIP_BIT] | r.flp;
				w[ROTATE_BIT] = w[ROTATE_BIT] | r.rot;
			end
			if (ok)
				tile_words[p] = w;
			return 1'b0;
		end
		if (op > OP_DRAW)
			return 1'b0;
		w = ok ? tile_words[p] : '0;
		e.raw_word = w;
		e.tile_index = w[18:0];
		e.is_mirrored = w[MIRROR_BIT];
		e.is_flipped = w[FLIP_BIT];
		e.is_rotated = w[ROTATE_BIT];
		e.in_range = ok;
		if (op == OP_DRAW) begin
			idx = longint'(w[18:0]);
			n = sheet_cols == 0 ? 1 : longint'(sheet_cols);
			e.draw_skip = !ok || idx == 0;
			if (!e.draw_skip) begin
				e.texel_x = 19'(longint'(gutter) +
					(idx % n) * (longint'(tw_px) + 2 * longint'(gutter)));
				e.texel_y = 19'(longint'(gutter) +
					(idx / n) * (longint'(th_px) + 2 * longint'(gutter)));
			end
			e.centre_x = pixel_centre(x, tw_px);
			e.centre_y = pixel_centre(y, th_px);
		end
		return 1'b1;
	endfunction

	task automatic offer(input logic [2:0] op, input cell_req_t r, input bit pinned,
		input cell_res_t pin);
		cell_res_t want;
		bit        taken;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		s_tuser <= op;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		if (lookup_cell(op, r, want))
			expected_cells.push_back(pinned ? pin : want);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(negedge clk);
		while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAP_WIDTH:  grid_w = 13'(v);
			REG_MAP_HEIGHT: grid_h = 13'(v);
			REG_ATLAS_COLS: sheet_cols = 11'(v);
			REG_TILE_W:     tw_px = 9'(v);
			REG_TILE_H:     th_px = 9'(v);
			REG_PADDING:    gutter = 4'(v);
			default: ;
		endcase
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (seen !== want) begin
			if (mismatches < 10)
				$display("result %0d %s: expected %h, got %h", cells_seen, name, want, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(negedge clk) begin : watch_results
		cell_res_t seen, want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata;
			if (expected_cells.size() == 0) begin
				if (mismatches < 10)
					$display("result %0d with nothing expected: %h", cells_seen, m_tdata);
				mismatches++;
			end else begin
				want = expected_cells.pop_front();
				compare_field("raw_word", want.raw_word, seen.raw_word);
				compare_field("tile_index", want.tile_index, seen.tile_index);
				compare_field("is_mirrored", want.is_mirrored, seen.is_mirrored);
				compare_field("is_flipped", want.is_flipped, seen.is_flipped);
				compare_field("is_rotated", want.is_rotated, seen.is_rotated);
				compare_field("in_range", want.in_range, seen.in_range);
				compare_field("draw_skip", want.draw_skip, seen.draw_skip);
				compare_field("texel_x", want.texel_x, seen.texel_x);
				compare_field("texel_y", want.texel_y, seen.texel_y);
				compare_field("centre_x", want.centre_x, seen.centre_x);
				compare_field("centre_y", want.centre_y, seen.centre_y);
				compare_field("fill", want.fill, seen.fill);
			end
			cells_seen++;
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tile_map_store_and_lookup_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		script_row_t script [] = '{
			'{OP_RD_RAW,      0,     0, 32'h0,         3'b000, 1'b1, 1'b1, 1'b0, 0, 0},
			'{OP_RD_UNP,     63,    63, 32'h0,         3'b000, 1'b1, 1'b1, 1'b0, 0, 0},
			'{OP_RD_RAW,     -1,     0, 32'h0,         3'b000, 1'b1, 1'b0, 1'b0, 0, 0},
			'{OP_RD_UNP,      0,    64, 32'h0,         3'b000, 1'b1, 1'b0, 1'b0, 0, 0},
			'{OP_DRAW,        0,     0, 32'h0,         3'b000, 1'b1, 1'b1, 1'b1, 8, 8},
			'{OP_DRAW,    -8192, -8192, 32'h0,         3'b000, 1'b1, 1'b0, 1'b1,
				-131064, -131064},
			'{OP_DRAW,     8191,  8191, 32'h0,         3'b000, 1'b1, 1'b0, 1'b1,
				131064, 131064},
			'{OP_WR_RAW,      0,     0, 32'hFFFF_FFFF, 3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_RAW,      0,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_UNP,      0,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_DRAW,        0,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_FLAG,     1,     0, 32'h0000_0005, 3'b111, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_UNP,      1,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_DRAW,        1,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_FLAG,     2,     0, 32'h8000_0000, 3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_DRAW,        2,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_RAW,     65,     0, 32'h0007_FFFF, 3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_RAW,      1,     1, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_DRAW,        1,     1, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_RAW,  -8192, -8192, 32'h1234_5678, 3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_FLAG,  8191,  8191, 32'h0,         3'b111, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_RAW,   8191,  8191, 32'h0,         3'b000, 1'b1, 1'b0, 1'b0, 0, 0},
			'{OP_SPARE_LO,    0,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_SPARE_HI,    1,     0, 32'hDEAD_BEEF, 3'b111, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_RAW,      0,     0, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_WR_FLAG,    63,    63, 32'h0,         3'b001, 1'b0, 1'b0, 1'b0, 0, 0},
			'{OP_RD_UNP,     63,    63, 32'h0,         3'b000, 1'b0, 1'b0, 1'b0, 0, 0}
		};
		map_shape_t shapes [] = '{
			'{5, 3, 3, 8, 4, 2},
			'{8191, 8191, 2047, 511, 511, 15},
			'{1, 1, 0, 1, 1, 0},
			'{4096, 4096, 1024, 256, 256, 15},
			'{1, 4096, 1, 255, 7, 9},
			'{64, 64, 16, 16, 16, 0}
		};
		map_shape_t shape;
		cell_req_t  r;
		cell_res_t  pin;
		logic [2:0] op;
		longint     lim;
		int         pos, x, y, roll, where;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			r = '0;
			r.cx = 14'(script[i].x);
			r.cy = 14'(script[i].y);
			r.word = script[i].word;
			{r.rot, r.flp, r.mir} = script[i].flags;
			pin = '0;
			pin.in_range = script[i].e_inr;
			pin.draw_skip = script[i].e_skip;
			pin.centre_x = 22'(script[i].e_cx);
			pin.centre_y = 22'(script[i].e_cy);
			offer(script[i].op, r, script[i].pinned, pin);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < shapes.size())
				shape = shapes[ph];
			else
				shape = '{$urandom_range(1, 200), $urandom_range(1, 200),
					$urandom_range(0, 40), $urandom_range(1, 511),
					$urandom_range(1, 511), $urandom_range(0, 15)};
			write_reg(REG_MAP_WIDTH, shape.w);
			write_reg(REG_MAP_HEIGHT, shape.h);
			write_reg(REG_ATLAS_COLS, shape.cols);
			write_reg(REG_TILE_W, shape.tw);
			write_reg(REG_TILE_H, shape.th);
			write_reg(REG_PADDING, shape.pad);
			steady = (ph == 3);
			lim = longint'(grid_w) * longint'(grid_h);
			if (lim > MAP_DEPTH)
				lim = MAP_DEPTH;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 20)
					op = OP_WR_RAW;
				else if (roll < 38)
					op = OP_WR_FLAG;
				else if (roll < 52)
					op = OP_RD_RAW;
				else if (roll < 64)
					op = OP_RD_UNP;
				else if (roll < 95)
					op = OP_DRAW;
				else
					op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				r = '0;
				r.word = $urandom;
				if ($urandom_range(1))
					r.word[18:0] = 19'($urandom_range(0, 40));
				{r.rot, r.flp, r.mir} = 3'($urandom);
				where = $urandom_range(99);
				if (where < 75) begin
					// keep two in five items on the first 48 cells when the map has more, so reads hit earlier writes
					pos = $urandom_range(0, (where < 40 && lim > 48) ? 47 : int'(lim - 1));
					x = pos % int'(grid_w);
					y = pos / int'(grid_w);
					if (y > 0 && $urandom_range(9) == 0) begin
						x += int'(grid_w);
						y -= 1;
					end
					r.cx = 14'(x);
					r.cy = 14'(y);
				end else if (where < 90) begin
					r.cx = 14'(int'($urandom_range(0, int'(grid_w) + 3)) - 2);
					r.cy = 14'(int'($urandom_range(0, int'(grid_h) + 2)) - 1);
				end else begin
					r.cx = 14'($urandom);
					r.cy = 14'($urandom);
				end
				offer(op, r, 1'b0, '0);
			end
		end

		steady = 1'b0;
		settle();
		if (mismatches == 0)
			$display("tile_map_store_and_lookup_top regression: pass");
		else
			$display("tile_map_store_and_lookup_top regression: fail");
		$finish;
	end

endmodule
